// ----- rtl/kinematic_trajectory_rollout_defines.svh -----
// Assertion macros used by the checker file of the trajectory rollout block.
`ifndef KINEMATIC_TRAJECTORY_ROLLOUT_DEFINES_SVH
`define KINEMATIC_TRAJECTORY_ROLLOUT_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define KTR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define KTR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/ktr_pkg.sv -----
// Shared types, constants and arithmetic helpers of the trajectory rollout block.
package ktr_pkg;

    localparam int MUL_W  = 34;
    localparam int PROD_W = 2 * MUL_W;

    localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
    localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [34:0] TWO_PI_Q30  = 35'sd6746518852;
    localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;

    // Configuration register indexes
    localparam logic [2:0] REG_ACCEL_X    = 3'd0;
    localparam logic [2:0] REG_DECEL_X    = 3'd1;
    localparam logic [2:0] REG_ACCEL_Y    = 3'd2;
    localparam logic [2:0] REG_DECEL_Y    = 3'd3;
    localparam logic [2:0] REG_ACCEL_TURN = 3'd4;
    localparam logic [2:0] REG_DECEL_TURN = 3'd5;
    localparam logic [2:0] REG_TIME_STEP  = 3'd6;
    localparam logic [2:0] REG_STEP_COUNT = 3'd7;

    typedef struct packed {
        logic signed [MUL_W-1:0] cos_v;
        logic signed [MUL_W-1:0] sin_v;
    } ktr_trig_t;

    // Arctangent of 2^-i in Q2.30, truncated
    function automatic logic signed [33:0] ktr_atan(input logic [4:0] i);
        logic signed [33:0] r;
        case (i)
            5'd0:  r = 34'sd843314856;
            5'd1:  r = 34'sd497837829;
            5'd2:  r = 34'sd263043836;
            5'd3:  r = 34'sd133525158;
            5'd4:  r = 34'sd67021686;
            5'd5:  r = 34'sd33543515;
            5'd6:  r = 34'sd16775850;
            5'd7:  r = 34'sd8388437;
            5'd8:  r = 34'sd4194282;
            5'd9:  r = 34'sd2097149;
            5'd10: r = 34'sd1048575;
            5'd11: r = 34'sd524287;
            5'd12: r = 34'sd262143;
            5'd13: r = 34'sd131071;
            5'd14: r = 34'sd65535;
            5'd15: r = 34'sd32767;
            5'd16: r = 34'sd16383;
            5'd17: r = 34'sd8191;
            5'd18: r = 34'sd4095;
            5'd19: r = 34'sd2047;
            5'd20: r = 34'sd1023;
            5'd21: r = 34'sd511;
            5'd22: r = 34'sd255;
            5'd23: r = 34'sd127;
            default: r = 34'sd0;
        endcase
        return r;
    endfunction

    // Saturate a wide sum to 32-bit signed
    function automatic logic signed [31:0] ktr_sat32(input logic signed [PROD_W:0] v);
        logic signed [31:0] r;
        if (v > (PROD_W+1)'(32'sh7fffffff))
            r = 32'sh7fffffff;
        else if (v < (PROD_W+1)'(-33'sh80000000))
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // Step a velocity toward its target and clamp at the target
    function automatic logic signed [31:0] ktr_ramp(input logic signed [31:0] cur,
                                                    input logic signed [31:0] tgt,
                                                    input logic signed [PROD_W:0] sum);
        logic signed [31:0] v;
        logic signed [31:0] r;
        v = ktr_sat32(sum);
        if (cur < tgt)
            r = (v < tgt) ? v : tgt;
        else
            r = (v > tgt) ? v : tgt;
        return r;
    endfunction

endpackage

// ----- rtl/ktr_mul.sv -----
// Shared signed multiplier with a registered product.
module ktr_mul (
    input  logic                                  aclk,
    input  logic signed [ktr_pkg::MUL_W-1:0]      op_a,
    input  logic signed [ktr_pkg::MUL_W-1:0]      op_b,
    output logic signed [ktr_pkg::PROD_W-1:0]     prod
);

    logic signed [ktr_pkg::PROD_W-1:0] prod_reg;

    // Register every product
    always_ff @(posedge aclk) begin
        prod_reg <= ktr_pkg::PROD_W'(op_a) * ktr_pkg::PROD_W'(op_b);
    end

    assign prod = prod_reg;

endmodule

// ----- rtl/ktr_cordic.sv -----
// Iterative range reduction and rotation-mode CORDIC giving cosine and sine of a heading.
module ktr_cordic #(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_ITERS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic signed [31:0]  heading,
    output logic                done,
    output ktr_pkg::ktr_trig_t  trig
);

    localparam int ZW  = 62 - FRAC_BITS;
    localparam int RED = ZW - 32;
    localparam int SH  = 30 - FRAC_BITS;
    localparam int NI  = (CORDIC_ITERS < 24) ? CORDIC_ITERS : 24;

    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_RED  = 2'd1;
    localparam logic [1:0] C_FIX  = 2'd2;
    localparam logic [1:0] C_ITER = 2'd3;

    logic [1:0]         state_reg;
    logic               done_reg;
    logic [4:0]         cnt_reg;
    logic [ZW-1:0]      u_reg;
    logic [ZW-1:0]      d_reg;
    logic               neg_reg;
    logic               flip_reg;
    logic signed [33:0] x_reg;
    logic signed [33:0] y_reg;
    logic signed [33:0] z_reg;
    ktr_pkg::ktr_trig_t trig_reg;

    logic signed [ZW-1:0] zs;
    logic signed [34:0]   r0;
    logic signed [34:0]   r1;
    logic signed [34:0]   r2;
    logic signed [34:0]   r3;
    logic                 fold;
    logic signed [33:0]   xs;
    logic signed [33:0]   ys;
    logic signed [33:0]   xn;
    logic signed [33:0]   yn;

    // Heading moved to Q30
    assign zs = ZW'(heading) <<< SH;

    // Wrap into (-pi, pi] and fold into [-pi/2, pi/2]
    always_comb begin
        r0 = {1'b0, u_reg[33:0]};
        r1 = (neg_reg && (r0 != 35'sd0)) ? (ktr_pkg::TWO_PI_Q30 - r0) : r0;
        r2 = (r1 > ktr_pkg::PI_Q30) ? (r1 - ktr_pkg::TWO_PI_Q30) : r1;
        fold = 1'b1;
        if (r2 > ktr_pkg::HALF_PI_Q30)
            r3 = r2 - ktr_pkg::PI_Q30;
        else if (r2 < -ktr_pkg::HALF_PI_Q30)
            r3 = r2 + ktr_pkg::PI_Q30;
        else begin
            r3 = r2;
            fold = 1'b0;
        end
    end

    // One rotation step
    always_comb begin
        xs = x_reg >>> cnt_reg;
        ys = y_reg >>> cnt_reg;
        if (!z_reg[33]) begin
            xn = x_reg - ys;
            yn = y_reg + xs;
        end else begin
            xn = x_reg + ys;
            yn = y_reg - xs;
        end
    end

    // Sequence reduction then rotation
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                C_IDLE: if (start) state_reg <= C_RED;
                C_RED:  if (cnt_reg == 5'd0) state_reg <= C_FIX;
                C_FIX:  state_reg <= C_ITER;
                C_ITER: if (cnt_reg == 5'(NI - 1)) begin
                    state_reg <= C_IDLE;
                    done_reg  <= 1'b1;
                end
                default: state_reg <= C_IDLE;
            endcase
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            C_IDLE: begin
                neg_reg <= zs[ZW-1];
                u_reg   <= zs[ZW-1] ? ZW'(-zs) : ZW'(zs);
                d_reg   <= ZW'(ktr_pkg::TWO_PI_Q30) << (RED - 1);
                cnt_reg <= 5'(RED - 1);
            end
            C_RED: begin
                if (u_reg >= d_reg) u_reg <= u_reg - d_reg;
                d_reg   <= d_reg >> 1;
                cnt_reg <= cnt_reg - 5'd1;
            end
            C_FIX: begin
                z_reg    <= r3[33:0];
                flip_reg <= fold;
                x_reg    <= ktr_pkg::GAIN_Q30;
                y_reg    <= 34'sd0;
                cnt_reg  <= 5'd0;
            end
            default: begin
                x_reg   <= xn;
                y_reg   <= yn;
                z_reg   <= z_reg[33] ? (z_reg + ktr_pkg::ktr_atan(cnt_reg))
                                     : (z_reg - ktr_pkg::ktr_atan(cnt_reg));
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(NI - 1)) begin
                    trig_reg.cos_v <= flip_reg ? -xn : xn;
                    trig_reg.sin_v <= flip_reg ? -yn : yn;
                end
            end
        endcase
    end

    assign done = done_reg;
    assign trig = trig_reg;

endmodule

// ----- rtl/kinematic_trajectory_rollout.sv -----
// Top level: trajectory rollout sequencer around a shared multiplier and CORDIC unit.
// The start pose is offered in the cycle after an input word is accepted.
// Each later pose runs RED = 30 - FRAC_BITS reduction steps and NI CORDIC iterations
// in the CORDIC loop and ten products through the single multiplier; one input word
// is taken per trajectory of n poses, and no new word is taken until its last pose
// has been sent. Reset (aresetn low, synchronous) idles.
module kinematic_trajectory_rollout #(
    parameter int MAX_STEPS    = 64,
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_ITERS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    // start_x, start_y, start_heading, cur_vel_x, cur_vel_y, cur_turn_rate,
    // cmd_vel_x, cmd_vel_y, cmd_turn_rate
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [287:0] s_tdata,
    // pose_x, pose_y, pose_heading, pose_index, zero pad
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int PW = ktr_pkg::PROD_W;
    localparam int MW = ktr_pkg::MUL_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EMIT = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_ACC  = 3'd3;
    localparam logic [2:0] ST_TGO  = 3'd4;
    localparam logic [2:0] ST_TWT  = 3'd5;

    localparam logic [3:0] MOP_RX = 4'd0;
    localparam logic [3:0] MOP_RY = 4'd1;
    localparam logic [3:0] MOP_RT = 4'd2;
    localparam logic [3:0] MOP_XC = 4'd3;
    localparam logic [3:0] MOP_YS = 4'd4;
    localparam logic [3:0] MOP_WX = 4'd5;
    localparam logic [3:0] MOP_XS = 4'd6;
    localparam logic [3:0] MOP_YC = 4'd7;
    localparam logic [3:0] MOP_WY = 4'd8;
    localparam logic [3:0] MOP_TH = 4'd9;

    logic signed [31:0] accel_x_reg, decel_x_reg, accel_y_reg, decel_y_reg;
    logic signed [31:0] accel_turn_reg, decel_turn_reg;
    logic [20:0]        time_step_reg;
    logic [6:0]         step_count_reg;

    logic [2:0]         state_reg;
    logic [3:0]         mop_reg;
    logic [6:0]         k_reg;
    logic [6:0]         n_reg;

    logic signed [31:0] sim_x_reg, sim_y_reg, sim_heading_reg;
    logic signed [31:0] vel_x_reg, vel_y_reg, turn_reg;
    logic signed [31:0] tgt_x_reg, tgt_y_reg, tgt_turn_reg;
    logic signed [PW:0] acc_reg;

    logic signed [MW-1:0] op_a;
    logic signed [MW-1:0] op_b;
    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] prod_sh;
    logic signed [31:0]   base;
    logic signed [PW:0]   sum;
    logic signed [MW-1:0] ts_ext;
    logic signed [MW-1:0] w_ext;
    logic                 trig_done;
    ktr_pkg::ktr_trig_t   trig;
    logic                 last;
    logic [6:0]           n_clamp;

    ktr_mul u_mul (
        .aclk (aclk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    ktr_cordic #(
        .FRAC_BITS    (FRAC_BITS),
        .CORDIC_ITERS (CORDIC_ITERS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (state_reg == ST_TGO),
        .heading (sim_heading_reg),
        .done    (trig_done),
        .trig    (trig)
    );

    // Configuration writes
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accel_x_reg    <= 32'sd65536;
            decel_x_reg    <= -32'sd65536;
            accel_y_reg    <= 32'sd65536;
            decel_y_reg    <= -32'sd65536;
            accel_turn_reg <= 32'sd65536;
            decel_turn_reg <= -32'sd65536;
            time_step_reg  <= 21'd32768;
            step_count_reg <= 7'd6;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                ktr_pkg::REG_ACCEL_X:    accel_x_reg    <= cfg_data;
                ktr_pkg::REG_DECEL_X:    decel_x_reg    <= cfg_data;
                ktr_pkg::REG_ACCEL_Y:    accel_y_reg    <= cfg_data;
                ktr_pkg::REG_DECEL_Y:    decel_y_reg    <= cfg_data;
                ktr_pkg::REG_ACCEL_TURN: accel_turn_reg <= cfg_data;
                ktr_pkg::REG_DECEL_TURN: decel_turn_reg <= cfg_data;
                ktr_pkg::REG_TIME_STEP:  time_step_reg  <= cfg_data[20:0];
                ktr_pkg::REG_STEP_COUNT: step_count_reg <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // Clamp the pose count into one to MAX_STEPS
    always_comb begin
        if (step_count_reg == 7'd0)
            n_clamp = 7'd1;
        else if (step_count_reg > 7'(MAX_STEPS))
            n_clamp = 7'(MAX_STEPS);
        else
            n_clamp = step_count_reg;
    end

    assign ts_ext = MW'($signed({1'b0, time_step_reg}));
    assign w_ext  = acc_reg[MW+29:30];

    // Select multiplier operands per micro-op
    always_comb begin
        op_a = '0;
        op_b = ts_ext;
        case (mop_reg)
            MOP_RX: op_a = MW'((vel_x_reg < tgt_x_reg) ? accel_x_reg : decel_x_reg);
            MOP_RY: op_a = MW'((vel_y_reg < tgt_y_reg) ? accel_y_reg : decel_y_reg);
            MOP_RT: op_a = MW'((turn_reg < tgt_turn_reg) ? accel_turn_reg
                                                          : decel_turn_reg);
            MOP_XC: begin op_a = MW'(vel_x_reg); op_b = trig.cos_v; end
            MOP_YS: begin op_a = MW'(vel_y_reg); op_b = trig.sin_v; end
            MOP_WX: op_a = w_ext;
            MOP_XS: begin op_a = MW'(vel_x_reg); op_b = trig.sin_v; end
            MOP_YC: begin op_a = MW'(vel_y_reg); op_b = trig.cos_v; end
            MOP_WY: op_a = w_ext;
            MOP_TH: op_a = MW'(turn_reg);
            default: op_a = '0;
        endcase
    end

    // Shared add of a state value and the scaled product
    always_comb begin
        case (mop_reg)
            MOP_RX:  base = vel_x_reg;
            MOP_RY:  base = vel_y_reg;
            MOP_RT:  base = turn_reg;
            MOP_WX:  base = sim_x_reg;
            MOP_WY:  base = sim_y_reg;
            default: base = sim_heading_reg;
        endcase
        prod_sh = prod >>> FRAC_BITS;
        sum = (PW+1)'(base) + (PW+1)'(prod_sh);
    end

    assign last = (k_reg == (n_reg - 7'd1));

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mop_reg   <= MOP_RX;
            k_reg     <= 7'd0;
            n_reg     <= 7'd1;
        end else begin
            unique case (state_reg)
                ST_IDLE: if (s_tvalid) begin
                    state_reg <= ST_EMIT;
                    k_reg     <= 7'd0;
                    n_reg     <= n_clamp;
                end
                ST_EMIT: if (m_tready) begin
                    if (last) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        state_reg <= ST_MUL;
                        mop_reg   <= MOP_RX;
                    end
                end
                ST_MUL: state_reg <= ST_ACC;
                ST_ACC: begin
                    if (mop_reg == MOP_RT) begin
                        state_reg <= ST_TGO;
                    end else if (mop_reg == MOP_TH) begin
                        state_reg <= ST_EMIT;
                        k_reg     <= k_reg + 7'd1;
                    end else begin
                        state_reg <= ST_MUL;
                        mop_reg   <= mop_reg + 4'd1;
                    end
                end
                ST_TGO: state_reg <= ST_TWT;
                ST_TWT: if (trig_done) begin
                    state_reg <= ST_MUL;
                    mop_reg   <= MOP_XC;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Simulation state
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_tvalid) begin
            sim_x_reg       <= s_tdata[31:0];
            sim_y_reg       <= s_tdata[63:32];
            sim_heading_reg <= s_tdata[95:64];
            vel_x_reg       <= s_tdata[127:96];
            vel_y_reg       <= s_tdata[159:128];
            turn_reg        <= s_tdata[191:160];
            tgt_x_reg       <= s_tdata[223:192];
            tgt_y_reg       <= s_tdata[255:224];
            tgt_turn_reg    <= s_tdata[287:256];
        end else if (state_reg == ST_ACC) begin
            case (mop_reg)
                MOP_RX: vel_x_reg <= ktr_pkg::ktr_ramp(vel_x_reg, tgt_x_reg, sum);
                MOP_RY: vel_y_reg <= ktr_pkg::ktr_ramp(vel_y_reg, tgt_y_reg, sum);
                MOP_RT: turn_reg  <= ktr_pkg::ktr_ramp(turn_reg, tgt_turn_reg, sum);
                MOP_XC: acc_reg   <= (PW+1)'(prod);
                MOP_YS: acc_reg   <= acc_reg - (PW+1)'(prod);
                MOP_WX: sim_x_reg <= ktr_pkg::ktr_sat32(sum);
                MOP_XS: acc_reg   <= (PW+1)'(prod);
                MOP_YC: acc_reg   <= acc_reg + (PW+1)'(prod);
                MOP_WY: sim_y_reg <= ktr_pkg::ktr_sat32(sum);
                MOP_TH: sim_heading_reg <= ktr_pkg::ktr_sat32(sum);
                default: ;
            endcase
        end
    end

    // Output word straight from the held pose
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_EMIT);
    assign m_tdata  = {2'b00, k_reg[5:0], sim_heading_reg, sim_y_reg, sim_x_reg};
    assign m_tlast  = last;

endmodule

// ----- rtl/ktr_checker.sv -----
// Port-level checker of the trajectory rollout block and its bind.
`include "kinematic_trajectory_rollout_defines.svh"

module ktr_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [103:0] m_tdata,
    input logic         m_tlast
);

    `KTR_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output word dropped or changed while stalled")
    `KTR_ASSERT_NOW(a_excl, s_tready, !m_tvalid, "input taken while a pose is pending")
    `KTR_ASSERT_NEXT(a_first, s_tvalid && s_tready, m_tvalid && (m_tdata[101:96] == 6'd0), "start pose missing after accept")
    `KTR_ASSERT_NEXT(a_done, m_tvalid && m_tready && m_tlast, s_tready, "not idle after final pose")

endmodule

bind kinematic_trajectory_rollout ktr_checker u_ktr_checker (.*);

// ----- tb/tb_kinematic_trajectory_rollout.sv -----
// Self-checking testbench for the kinematic trajectory rollout block.
`timescale 1ns / 100ps

module tb_kinematic_trajectory_rollout;

    localparam int      IDLE_LIMIT = 8000;
    localparam longint  Q30_PI      = 64'sd3373259426;
    localparam longint  Q30_HALF_PI = 64'sd1686629713;
    localparam longint  Q30_TWO_PI  = 64'sd6746518852;
    localparam longint  Q30_GAIN    = 64'sd652032874;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] heading;
        logic [5:0]  index;
        logic        last;
    } pose_t;

    typedef logic [31:0] plan_t [9];

    // Rollout model and queue of poses still to come out of the block
    class pose_scoreboard;
        longint    gain_up [3];
        longint    gain_down [3];
        longint    dt;
        int        poses_per_plan;
        pose_t     pose_q [$];
        int        errors;
        longint    atan_tab [16];

        function new();
            atan_tab = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
                         16775850, 8388437, 4194282, 2097149, 1048575, 524287,
                         262143, 131071, 65535, 32767};
            gain_up = '{65536, 65536, 65536};
            gain_down = '{-65536, -65536, -65536};
            dt = 32768;
            poses_per_plan = 6;
            errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                ktr_pkg::REG_ACCEL_X:    gain_up[0] = longint'(signed'(val));
                ktr_pkg::REG_DECEL_X:    gain_down[0] = longint'(signed'(val));
                ktr_pkg::REG_ACCEL_Y:    gain_up[1] = longint'(signed'(val));
                ktr_pkg::REG_DECEL_Y:    gain_down[1] = longint'(signed'(val));
                ktr_pkg::REG_ACCEL_TURN: gain_up[2] = longint'(signed'(val));
                ktr_pkg::REG_DECEL_TURN: gain_down[2] = longint'(signed'(val));
                ktr_pkg::REG_TIME_STEP:  dt = longint'(val[20:0]);
                ktr_pkg::REG_STEP_COUNT: poses_per_plan = int'(val[6:0]);
                default: ;
            endcase
        endfunction

        function longint clip32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint ramp_axis(longint cur, longint tgt, int ax);
            longint v;
            if (cur < tgt) begin
                v = clip32(cur + ((gain_up[ax] * dt) >>> 16));
                return (v < tgt) ? v : tgt;
            end
            v = clip32(cur + ((gain_down[ax] * dt) >>> 16));
            return (v > tgt) ? v : tgt;
        endfunction

        // Reduce heading to (-pi, pi], fold to the right half plane, rotate
        function void heading_trig(longint hd, output longint c, output longint s);
            longint z, x, y, nx;
            bit     flip;
            z = (hd * 64'sd16384) % Q30_TWO_PI;
            flip = 0;
            if (z < 0) z += Q30_TWO_PI;
            if (z > Q30_PI) z -= Q30_TWO_PI;
            if (z > Q30_HALF_PI) begin
                z -= Q30_PI;
                flip = 1;
            end else if (z < -Q30_HALF_PI) begin
                z += Q30_PI;
                flip = 1;
            end
            x = Q30_GAIN;
            y = 0;
            for (int i = 0; i < 16; i++) begin
                if (z >= 0) begin
                    nx = x - (y >>> i);
                    y = y + (x >>> i);
                    z -= atan_tab[i];
                end else begin
                    nx = x + (y >>> i);
                    y = y - (x >>> i);
                    z += atan_tab[i];
                end
                x = nx;
            end
            c = flip ? -x : x;
            s = flip ? -y : y;
        endfunction

        function void push_pose(longint px, longint py, longint ph, int k, int n);
            pose_t p;
            p.x = px[31:0];
            p.y = py[31:0];
            p.heading = ph[31:0];
            p.index = k[5:0];
            p.last = (k == n - 1);
            pose_q = {pose_q, p};
        endfunction

        // Accepted plan word: roll out the whole trajectory
        function void note_plan(plan_t f);
            longint px, py, ph, vel [3], tgt [3], c, s, wx, wy;
            int     n;
            n = poses_per_plan;
            if (n < 1) n = 1;
            if (n > 64) n = 64;
            px = signed'(f[0]);
            py = signed'(f[1]);
            ph = signed'(f[2]);
            for (int a = 0; a < 3; a++) begin
                vel[a] = signed'(f[3 + a]);
                tgt[a] = signed'(f[6 + a]);
            end
            push_pose(px, py, ph, 0, n);
            for (int k = 1; k < n; k++) begin
                for (int a = 0; a < 3; a++) vel[a] = ramp_axis(vel[a], tgt[a], a);
                heading_trig(ph, c, s);
                wx = (vel[0] * c - vel[1] * s) >>> 30;
                wy = (vel[0] * s + vel[1] * c) >>> 30;
                px = clip32(px + ((wx * dt) >>> 16));
                py = clip32(py + ((wy * dt) >>> 16));
                ph = clip32(ph + ((vel[2] * dt) >>> 16));
                push_pose(px, py, ph, k, n);
            end
        endfunction

        task report(string what, longint got, longint want);
            $display("mismatch %s: got %0h, expected %0h", what, got, want);
            errors++;
        endtask

        task check_pose(logic [103:0] data, logic last);
            pose_t p;
            if (pose_q.size() == 0) begin
                report("unexpected pose", data[101:96], 0);
                return;
            end
            p = pose_q.pop_front();
            if (data[31:0] !== p.x) report("pose_x", data[31:0], p.x);
            if (data[63:32] !== p.y) report("pose_y", data[63:32], p.y);
            if (data[95:64] !== p.heading) report("pose_heading", data[95:64], p.heading);
            if (data[101:96] !== p.index) report("pose_index", data[101:96], p.index);
            if (last !== p.last) report("last_pose", last, p.last);
        endtask
    endclass

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [287:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;
    logic         m_tlast;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [2:0]   cfg_index;
    logic [31:0]  cfg_data;

    pose_scoreboard sb = new();
    int             stall_left;
    bit             no_stall;
    int             idle_cycles;

    kinematic_trajectory_rollout DUT (.*);

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Random gap length: mostly short, sometimes long
    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 5) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Sink side: random stalls, check poses, watch for a hang
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left <= 0;
            idle_cycles <= 0;
        end else begin
            if (m_tvalid && m_tready) sb.check_pose(m_tdata, m_tlast);
            if (no_stall) begin
                m_tready <= 1'b1;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left <= stall_left - 1;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
            end
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Offer one plan word; gap zero keeps valid high back to back
    task automatic send_plan(plan_t f, int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {f[8], f[7], f[6], f[5], f[4], f[3], f[2], f[1], f[0]};
        do @(posedge aclk); while (!s_tready);
        sb.note_plan(f);
    endtask

    // Drain all poses before touching the registers again
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pose_q.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_field(bit small_val);
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0;
            3, 4: return $urandom();
            default: return small_val ? 32'($signed($urandom_range(0, 524288)) - 262144)
                                      : $urandom();
        endcase
    endfunction

    function automatic plan_t rand_plan();
        plan_t f;
        bool_dummy: begin end
        for (int i = 0; i < 9; i++) f[i] = rand_field(i >= 3);
        // Now and then copy cur_vel_x into one randomly chosen command field
        if ($urandom_range(0, 5) == 0) f[6 + $urandom_range(0, 2)] = f[3];
        return f;
    endfunction

    task automatic run_random(int count);
        for (int i = 0; i < count; i++) send_plan(rand_plan(), pick_gap());
        drain();
    endtask

    task automatic random_gains();
        for (int r = 0; r < 6; r++) begin
            if ($urandom_range(0, 3) == 0)
                cfg_write(3'(r), $urandom());
            else
                cfg_write(3'(r), (r % 2 == 0) ? $urandom_range(1, 262144)
                                              : 32'(-$signed($urandom_range(1, 262144))));
        end
    endtask

    initial begin
        plan_t f;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = ktr_pkg::REG_ACCEL_X;
        cfg_data = '0;
        no_stall = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed plans at reset defaults: extremes, ramp directions, heading folds
        no_stall <= 1'b1;
        f = '{default: 32'h0};
        send_plan(f, 0);
        f = '{default: 32'h7fff_ffff};
        send_plan(f, 0);
        f = '{default: 32'h8000_0000};
        send_plan(f, 1);
        f = '{32'h7fff_0000, 32'h8001_0000, 32'h0001_921f, 32'h0002_0000, 32'hfffe_0000,
              32'h0001_0000, 32'hfffe_0000, 32'h0002_0000, 32'h0001_0000};
        send_plan(f, 0);
        f = '{32'h0, 32'h0, 32'hfffe_6de1, 32'h0, 32'h0, 32'h0,
              32'h0003_0000, 32'hfffd_0000, 32'hffff_0000};
        send_plan(f, 0);
        f = '{32'h0, 32'h0, 32'h0003_243f, 32'h0001_0000, 32'h0001_0000, 32'h0,
              32'h0001_0000, 32'h0001_0000, 32'h0};
        send_plan(f, 2);
        f = '{32'h0, 32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
              32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff};
        send_plan(f, 0);
        f = '{32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
              32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
        send_plan(f, 0);
        drain();

        // Negative accel and positive decel on x and turn, extreme y gains, time step 2^20, longest trajectory
        cfg_write(ktr_pkg::REG_ACCEL_X, 32'hfffe_0000);
        cfg_write(ktr_pkg::REG_DECEL_X, 32'h0002_0000);
        cfg_write(ktr_pkg::REG_ACCEL_Y, 32'h7fff_ffff);
        cfg_write(ktr_pkg::REG_DECEL_Y, 32'h8000_0000);
        cfg_write(ktr_pkg::REG_ACCEL_TURN, 32'h8000_0000);
        cfg_write(ktr_pkg::REG_DECEL_TURN, 32'h7fff_ffff);
        cfg_write(ktr_pkg::REG_TIME_STEP, 32'd1048576);
        cfg_write(ktr_pkg::REG_STEP_COUNT, 32'd64);
        no_stall <= 1'b0;
        run_random(6);

        // Zero time step and zero step count
        cfg_write(ktr_pkg::REG_TIME_STEP, 32'd0);
        cfg_write(ktr_pkg::REG_STEP_COUNT, 32'd0);
        run_random(8);

        // Oversized step count, smallest nonzero time step
        cfg_write(ktr_pkg::REG_TIME_STEP, 32'd1);
        cfg_write(ktr_pkg::REG_STEP_COUNT, 32'd127);
        run_random(3);

        // Random settings with short trajectories
        for (int ph = 0; ph < 8; ph++) begin
            random_gains();
            cfg_write(ktr_pkg::REG_TIME_STEP,
                      (ph == 3) ? 32'h001f_ffff : $urandom_range(1, 1048576));
            cfg_write(ktr_pkg::REG_STEP_COUNT, (ph == 5) ? 32'd1 : $urandom_range(2, 8));
            no_stall <= (ph % 3 == 2);
            run_random(40);
        end

        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/ktr_pkg.sv
rtl/ktr_mul.sv
rtl/ktr_cordic.sv
rtl/kinematic_trajectory_rollout.sv
rtl/ktr_checker.sv
tb/tb_kinematic_trajectory_rollout.sv
